// ===== design/sitrd_pkg.sv =====
// sitrd_pkg: shared types and constants for the signed integer to radix digits unit
// no dependencies; used by sitrd_ctrl, sitrd_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package sitrd_pkg;

   localparam int NUM_W      = 32;
   localparam int SYM_W      = 8;
   localparam int RADIX_W    = 5;
   localparam int DIGIT_W    = 4;
   localparam int SYM_COUNT  = 16;
   localparam int COUNT_W    = 6;
   localparam int MAX_DIGITS = 32;
   localparam int MAX_BASE   = 16;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // register index, taken from paddr[4:3]
   localparam logic [1:0] REG_RADIX        = 2'd0;
   localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
   localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

   localparam logic [RADIX_W-1:0]    RADIX_RESET        = 5'd10;
   localparam logic [CSR_DATA_W-1:0] SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_W-1:0] SYMBOLS_HIGH_RESET = 64'h0000_0000_0000_3938;

   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

   typedef struct packed {
      logic load;
      logic mul;
      logic div;
      logic out_sign;
      logic out_digit;
      logic out_error;
   } dp_cmd_type;

   typedef struct packed {
      logic err;
      logic neg;
      logic mag_zero;
      logic count_zero;
      logic count_full;
      logic last_digit;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/sitrd_ctrl.sv =====
// sitrd_ctrl: sequencing state machine for conversion and byte output
// depends on sitrd_pkg; drives sitrd_datapath through command and status structs
`timescale 1ns / 1ps
`default_nettype none

module sitrd_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire sitrd_pkg::dp_status_type status,
   output sitrd_pkg::dp_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_SIGN   = 3'd3;
   localparam logic [2:0] ST_DIGITS = 3'd4;
   localparam logic [2:0] ST_ERROR  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       slot_free;
   logic       out_load;

   assign slot_free  = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (status.err) begin
               state_in = ST_ERROR;
            end else if (!status.count_zero && (status.mag_zero || status.count_full)) begin
               state_in = status.neg ? ST_SIGN : ST_DIGITS;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div  = 1'b1;
            state_in = ST_MUL;
         end
         ST_SIGN: begin
            if (slot_free) begin
               cmd.out_sign = 1'b1;
               state_in     = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (slot_free) begin
               cmd.out_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERROR: begin
            if (slot_free) begin
               cmd.out_error = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_load = cmd.out_sign || cmd.out_digit || cmd.out_error;
   assign valid_in = out_load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sitrd_datapath.sv =====
// sitrd_datapath: magnitude, reciprocal divider, digit stack, alphabet check, output register
// depends on sitrd_pkg; commanded by sitrd_ctrl
`timescale 1ns / 1ps
`default_nettype none

module sitrd_datapath #(
   parameter int MAX_BASE = sitrd_pkg::MAX_BASE
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire sitrd_pkg::dp_cmd_type                  cmd,
   output sitrd_pkg::dp_status_type                    status,
   input  wire logic signed [sitrd_pkg::NUM_W-1:0]     number,
   input  wire logic [sitrd_pkg::RADIX_W-1:0]          radix,
   input  wire logic [sitrd_pkg::CSR_DATA_W-1:0]       symbols_low,
   input  wire logic [sitrd_pkg::CSR_DATA_W-1:0]       symbols_high,
   output logic [sitrd_pkg::SYM_W-1:0]                 symbol,
   output logic                                        last,
   output logic                                        base_error
);

   localparam int NW = sitrd_pkg::NUM_W;
   localparam int RW = sitrd_pkg::RADIX_W;
   localparam int DW = sitrd_pkg::DIGIT_W;
   localparam int SW = sitrd_pkg::SYM_W;
   localparam int CW = sitrd_pkg::COUNT_W;

   // floor(2^32 / n), estimate is exact or one low
   function automatic logic [NW-1:0] recip(input logic [RW-1:0] n);
      logic [NW-1:0] m;
      case (n)
         5'd2:    m = 32'h8000_0000;
         5'd3:    m = 32'h5555_5555;
         5'd4:    m = 32'h4000_0000;
         5'd5:    m = 32'h3333_3333;
         5'd6:    m = 32'h2AAA_AAAA;
         5'd7:    m = 32'h2492_4924;
         5'd8:    m = 32'h2000_0000;
         5'd9:    m = 32'h1C71_C71C;
         5'd10:   m = 32'h1999_9999;
         5'd11:   m = 32'h1745_D174;
         5'd12:   m = 32'h1555_5555;
         5'd13:   m = 32'h13B1_3B13;
         5'd14:   m = 32'h1249_2492;
         5'd15:   m = 32'h1111_1111;
         5'd16:   m = 32'h1000_0000;
         default: m = '0;
      endcase
      return m;
   endfunction

   logic [SW-1:0]   syms [sitrd_pkg::SYM_COUNT];
   logic [RW-1:0]   n;
   logic            alpha_ok;

   logic [NW-1:0]   mag_ff, mag_in;
   logic [NW-1:0]   qest_ff;
   logic            neg_ff;
   logic            err_ff;
   logic [CW-1:0]   count_ff, count_in;
   logic [DW-1:0]   digits_ff [sitrd_pkg::MAX_DIGITS];

   logic [NW-1:0]   raw;
   logic [2*NW-1:0] prod;
   logic [NW+RW-1:0] qn;
   logic [NW-1:0]   rem_full;
   logic            rem_ge;
   logic [NW-1:0]   rem_fix;
   logic [DW-1:0]   digit_new;
   logic [DW-1:0]   digit_top;

   logic [SW-1:0]   symbol_ff;
   logic            last_ff;
   logic            error_ff;

   always_comb begin
      for (int k = 0; k < sitrd_pkg::SYM_COUNT / 2; k++) begin
         syms[k]                             = symbols_low[k*SW +: SW];
         syms[k + sitrd_pkg::SYM_COUNT / 2] = symbols_high[k*SW +: SW];
      end
   end

   assign n = (radix > RW'(MAX_BASE)) ? RW'(MAX_BASE) : radix;

   always_comb begin
      alpha_ok = (n >= RW'(2));
      for (int i = 0; i < MAX_BASE; i++) begin
         if (RW'(i) < n) begin
            if (syms[i] == '0 || syms[i] == sitrd_pkg::SYM_PLUS ||
                syms[i] == sitrd_pkg::SYM_MINUS) begin
               alpha_ok = 1'b0;
            end
            for (int j = i + 1; j < MAX_BASE; j++) begin
               if (RW'(j) < n && syms[j] == syms[i]) begin
                  alpha_ok = 1'b0;
               end
            end
         end
      end
   end

   assign raw       = number;
   assign prod      = (2*NW)'(mag_ff) * (2*NW)'(recip(n));
   assign qn        = (NW+RW)'(qest_ff) * (NW+RW)'(n);
   assign rem_full  = mag_ff - qn[NW-1:0];
   assign rem_ge    = (rem_full >= NW'(n));
   assign rem_fix   = rem_ge ? (rem_full - NW'(n)) : rem_full;
   assign digit_new = rem_fix[DW-1:0];
   assign digit_top = digits_ff[count_ff[CW-2:0] - (CW-1)'(1)];

   always_comb begin
      mag_in   = mag_ff;
      count_in = count_ff;
      if (cmd.load) begin
         mag_in   = raw[NW-1] ? (NW'(0) - raw) : raw;
         count_in = '0;
      end else if (cmd.div) begin
         mag_in   = rem_ge ? (qest_ff + NW'(1)) : qest_ff;
         count_in = count_ff + CW'(1);
      end else if (cmd.out_digit) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      if (cmd.load) begin
         neg_ff <= raw[NW-1];
         err_ff <= !alpha_ok;
      end
      if (cmd.mul) begin
         qest_ff <= prod[2*NW-1:NW];
      end
      if (cmd.div) begin
         digits_ff[count_ff[CW-2:0]] <= digit_new;
      end
      if (cmd.out_sign) begin
         symbol_ff <= sitrd_pkg::SYM_MINUS;
         last_ff   <= 1'b0;
         error_ff  <= 1'b0;
      end else if (cmd.out_digit) begin
         symbol_ff <= syms[digit_top];
         last_ff   <= (count_ff == CW'(1));
         error_ff  <= 1'b0;
      end else if (cmd.out_error) begin
         symbol_ff <= '0;
         last_ff   <= 1'b1;
         error_ff  <= 1'b1;
      end
   end

   assign status.err        = err_ff;
   assign status.neg        = neg_ff;
   assign status.mag_zero   = (mag_ff == '0);
   assign status.count_zero = (count_ff == '0);
   assign status.count_full = (count_ff == CW'(sitrd_pkg::MAX_DIGITS));
   assign status.last_digit = (count_ff == CW'(1));

   assign symbol     = symbol_ff;
   assign last       = last_ff;
   assign base_error = error_ff;

endmodule

`default_nettype wire

// ===== design/signed_integer_to_radix_digits_unit.sv =====
// Converts a signed 32-bit number into radix text, one symbol byte per transaction,
// most significant first, with a leading '-' for negative values. An invalid digit
// alphabet gives a single transaction with tuser set and tlast set. The digits of a number are
// found in a divide loop after it is taken (a reciprocal multiply state and a correct-and-push
// state per digit, then a check that sees the end), then one output byte per cycle while the
// result side keeps up; the next number is taken once the last byte has been loaded.
// Depends on sitrd_pkg, sitrd_ctrl and sitrd_datapath.
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_to_radix_digits_unit #(
   parameter int MAX_BASE = sitrd_pkg::MAX_BASE
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic signed [sitrd_pkg::NUM_W-1:0]    req_tdata,   // [31:0] number
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [sitrd_pkg::SYM_W-1:0]                rsp_tdata,   // [7:0] symbol
   output logic                                       rsp_tlast,
   output logic                                       rsp_tuser,   // [0] base_error
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [sitrd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [sitrd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sitrd_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                       csr_pready
);

   logic [sitrd_pkg::RADIX_W-1:0]    radix_ff;
   logic [sitrd_pkg::CSR_DATA_W-1:0] symbols_low_ff;
   logic [sitrd_pkg::CSR_DATA_W-1:0] symbols_high_ff;
   logic                             csr_write;
   logic [1:0]                       csr_index;

   sitrd_pkg::dp_cmd_type    cmd;
   sitrd_pkg::dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff        <= sitrd_pkg::RADIX_RESET;
         symbols_low_ff  <= sitrd_pkg::SYMBOLS_LOW_RESET;
         symbols_high_ff <= sitrd_pkg::SYMBOLS_HIGH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            sitrd_pkg::REG_RADIX:        radix_ff <= csr_pwdata[sitrd_pkg::RADIX_W-1:0];
            sitrd_pkg::REG_SYMBOLS_LOW:  symbols_low_ff  <= csr_pwdata;
            sitrd_pkg::REG_SYMBOLS_HIGH: symbols_high_ff <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         sitrd_pkg::REG_RADIX:        csr_prdata = sitrd_pkg::CSR_DATA_W'(radix_ff);
         sitrd_pkg::REG_SYMBOLS_LOW:  csr_prdata = symbols_low_ff;
         sitrd_pkg::REG_SYMBOLS_HIGH: csr_prdata = symbols_high_ff;
         default:                     csr_prdata = '0;
      endcase
   end

   sitrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sitrd_datapath #(
      .MAX_BASE (MAX_BASE)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .number       (req_tdata),
      .radix        (radix_ff),
      .symbols_low  (symbols_low_ff),
      .symbols_high (symbols_high_ff),
      .symbol       (rsp_tdata),
      .last         (rsp_tlast),
      .base_error   (rsp_tuser)
   );

   // error transaction is always the only one of its number
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("error transaction without tlast");

   // a sign byte is never the final byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && rsp_tdata == sitrd_pkg::SYM_MINUS |-> !rsp_tlast)
      else $error("sign byte marked last");

   // busy after taking a number
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while converting");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for signed_integer_to_radix_digits_unit
// predicts the symbol bytes of each number from a local copy of the registers
// depends on sitrd_pkg and the design sources
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PCT    = 38;

   typedef struct packed {
      logic [sitrd_pkg::SYM_W-1:0] symbol;
      logic                        last;
      logic                        base_error;
   } text_byte_type;

   logic                              clock;
   logic                              reset       = 1'b1;
   logic                              req_tvalid  = 1'b0;
   logic                              req_tready;
   logic [sitrd_pkg::NUM_W-1:0]       req_tdata   = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready  = 1'b0;
   logic [sitrd_pkg::SYM_W-1:0]       rsp_tdata;
   logic                              rsp_tlast;
   logic                              rsp_tuser;
   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [sitrd_pkg::CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [sitrd_pkg::CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [sitrd_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                              csr_pready;

   // local copy of the registers
   logic [sitrd_pkg::RADIX_W-1:0]     radix_cfg        = sitrd_pkg::RADIX_RESET;
   logic [sitrd_pkg::CSR_DATA_W-1:0]  symbols_low_cfg  = sitrd_pkg::SYMBOLS_LOW_RESET;
   logic [sitrd_pkg::CSR_DATA_W-1:0]  symbols_high_cfg = sitrd_pkg::SYMBOLS_HIGH_RESET;

   text_byte_type expected_text[$];
   int            mismatch_count = 0;
   int            cycle_count    = 0;
   bit            calm_mode      = 1'b0;

   signed_integer_to_radix_digits_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void flag_mismatch(string msg);
      if (mismatch_count < 10)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endfunction

   function automatic logic [sitrd_pkg::SYM_W-1:0] symbol_of(logic [3:0] idx);
      return idx[3] ? symbols_high_cfg[idx[2:0]*8 +: 8] : symbols_low_cfg[idx[2:0]*8 +: 8];
   endfunction

   function automatic bit alphabet_valid(int unsigned n);
      logic [sitrd_pkg::SYM_W-1:0] c;
      if (n < 2)
         return 1'b0;
      for (int i = 0; i < n; i++) begin
         c = symbol_of(4'(i));
         if (c == 8'h00 || c == sitrd_pkg::SYM_PLUS || c == sitrd_pkg::SYM_MINUS)
            return 1'b0;
         for (int j = i + 1; j < n; j++)
            if (symbol_of(4'(j)) == c)
               return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_text(logic [sitrd_pkg::NUM_W-1:0] number);
      int unsigned                 n;
      logic [sitrd_pkg::NUM_W-1:0] mag;
      logic [3:0]                  digits [sitrd_pkg::MAX_DIGITS];
      int                          nd;
      n = (radix_cfg > sitrd_pkg::MAX_BASE) ? sitrd_pkg::MAX_BASE : radix_cfg;
      if (!alphabet_valid(n)) begin
         expected_text.push_back('{8'h00, 1'b1, 1'b1});
         return;
      end
      mag = number[sitrd_pkg::NUM_W-1] ? -number : number;
      nd = 0;
      do begin
         digits[nd] = 4'(mag % n);
         mag = mag / n;
         nd++;
      end while (mag != 0 && nd < sitrd_pkg::MAX_DIGITS);
      if (number[sitrd_pkg::NUM_W-1])
         expected_text.push_back('{sitrd_pkg::SYM_MINUS, 1'b0, 1'b0});
      for (int i = nd - 1; i >= 0; i--)
         expected_text.push_back('{symbol_of(digits[i]), i == 0, 1'b0});
   endfunction

   // result side: random stalls, compare each transaction, predict on input acceptance
   always @(posedge clock) begin
      rsp_tready <= calm_mode ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      text_byte_type got;
      text_byte_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tlast, rsp_tuser};
            if (expected_text.size() == 0) begin
               flag_mismatch($sformatf("unexpected transaction symbol=%h last=%b err=%b",
                                       got.symbol, got.last, got.base_error));
            end else begin
               want = expected_text.pop_front();
               if (got.symbol !== want.symbol || got.last !== want.last ||
                   got.base_error !== want.base_error)
                  flag_mismatch($sformatf(
                     "expected symbol=%h last=%b err=%b, got symbol=%h last=%b err=%b",
                     want.symbol, want.last, want.base_error,
                     got.symbol, got.last, got.base_error));
            end
         end
         if (req_tvalid && req_tready)
            predict_text(req_tdata);
      end
   end

   task automatic send_number(logic [sitrd_pkg::NUM_W-1:0] number);
      if (!calm_mode && $urandom_range(99) < IDLE_PCT) begin
         if (req_tvalid)
            req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < IDLE_PCT)
            @(posedge clock);
         req_tvalid <= 1'b1;
      end else if (!req_tvalid) begin
         req_tvalid <= 1'b1;
      end
      req_tdata <= number;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic wait_idle();
      if (req_tvalid)
         req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_text.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write one register, then read it back
   task automatic csr_write(logic [1:0] index, logic [sitrd_pkg::CSR_DATA_W-1:0] value);
      logic [sitrd_pkg::CSR_DATA_W-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      case (index)
         sitrd_pkg::REG_RADIX:        radix_cfg        = value[sitrd_pkg::RADIX_W-1:0];
         sitrd_pkg::REG_SYMBOLS_LOW:  symbols_low_cfg  = value;
         sitrd_pkg::REG_SYMBOLS_HIGH: symbols_high_cfg = value;
         default: ;
      endcase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (index == sitrd_pkg::REG_RADIX
             ? readback[sitrd_pkg::RADIX_W-1:0] !== value[sitrd_pkg::RADIX_W-1:0]
             : readback !== value)
         flag_mismatch($sformatf("register %0d read %h, expected %h", index, readback, value));
   endtask

   task automatic set_alphabet(logic [sitrd_pkg::RADIX_W-1:0] radix, logic [63:0] low,
                               logic [63:0] high);
      wait_idle();
      csr_write(sitrd_pkg::REG_RADIX, sitrd_pkg::CSR_DATA_W'(radix));
      csr_write(sitrd_pkg::REG_SYMBOLS_LOW, low);
      csr_write(sitrd_pkg::REG_SYMBOLS_HIGH, high);
   endtask

   function automatic logic [127:0] random_alphabet();
      bit           used [256];
      logic [127:0] a;
      logic [7:0]   b;
      used = '{default: 1'b0};
      a = '0;
      for (int i = 0; i < sitrd_pkg::SYM_COUNT; i++) begin
         do
            b = 8'($urandom_range(1, 255));
         while (b == sitrd_pkg::SYM_PLUS || b == sitrd_pkg::SYM_MINUS || used[b]);
         used[b] = 1'b1;
         a[i*8 +: 8] = b;
      end
      return a;
   endfunction

   function automatic logic [sitrd_pkg::NUM_W-1:0] random_number();
      logic [sitrd_pkg::NUM_W-1:0] n;
      case ($urandom_range(5))
         0: n = $urandom_range(300);
         1: n = -$urandom_range(1, 300);
         2: begin
            n = $urandom >> $urandom_range(31);
            if ($urandom_range(1))
               n = -n;
         end
         3: case ($urandom_range(3))
            0: n = 32'h8000_0000;
            1: n = 32'h7FFF_FFFF;
            2: n = 32'h0000_0000;
            default: n = 32'hFFFF_FFFF;
         endcase
         default: n = $urandom;
      endcase
      return n;
   endfunction

   task automatic test_decimal_defaults();
      send_number(32'd0);
      send_number(32'd1);
      send_number(-32'd1);
      send_number(32'd9);
      send_number(-32'd10);
      send_number(32'd12345);
      send_number(32'h7FFF_FFFF);
      send_number(32'h8000_0000);
   endtask

   task automatic test_radix_extremes();
      set_alphabet(5'd2, sitrd_pkg::SYMBOLS_LOW_RESET, sitrd_pkg::SYMBOLS_HIGH_RESET);
      send_number(32'h8000_0000);
      send_number(32'd0);
      send_number(32'd1);
      send_number(32'hFFFF_FFFF);
      set_alphabet(5'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
      send_number(32'h7FFF_FFFF);
      send_number(32'hFFFF_FFFF);
      send_number(32'h8000_0000);
      send_number(32'd0);
      // radix above the maximum saturates
      set_alphabet(5'd31, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
      send_number(32'hDEAD_BEEF);
   endtask

   task automatic test_invalid_alphabets();
      set_alphabet(5'd0, sitrd_pkg::SYMBOLS_LOW_RESET, sitrd_pkg::SYMBOLS_HIGH_RESET);
      send_number(32'd7);
      set_alphabet(5'd1, sitrd_pkg::SYMBOLS_LOW_RESET, sitrd_pkg::SYMBOLS_HIGH_RESET);
      send_number(-32'd7);
      set_alphabet(5'd10, 64'h3736_3534_2B32_3130, sitrd_pkg::SYMBOLS_HIGH_RESET);
      send_number(32'd42);
      set_alphabet(5'd10, sitrd_pkg::SYMBOLS_LOW_RESET, 64'h0000_0000_0000_2D38);
      send_number(32'd42);
      // symbol 10 is a zero byte
      set_alphabet(5'd11, sitrd_pkg::SYMBOLS_LOW_RESET, sitrd_pkg::SYMBOLS_HIGH_RESET);
      send_number(32'd42);
      set_alphabet(5'd10, 64'h3736_3534_3332_3131, sitrd_pkg::SYMBOLS_HIGH_RESET);
      send_number(32'd42);
      // minus sign outside the symbols in use is fine
      set_alphabet(5'd9, sitrd_pkg::SYMBOLS_LOW_RESET, 64'h0000_0000_0000_2D38);
      send_number(-32'd80);
   endtask

   task automatic test_random_conversions();
      logic [127:0]                  alpha;
      logic [sitrd_pkg::RADIX_W-1:0] radix;
      int                            pos;
      for (int p = 0; p < 12; p++) begin
         alpha = random_alphabet();
         radix = 5'($urandom_range(2, 16));
         case ($urandom_range(7))
            0: radix = 5'($urandom_range(31));
            1: alpha = {$urandom, $urandom, $urandom, $urandom};
            2: begin
               pos = $urandom_range(15);
               case ($urandom_range(3))
                  0: alpha[pos*8 +: 8] = sitrd_pkg::SYM_PLUS;
                  1: alpha[pos*8 +: 8] = sitrd_pkg::SYM_MINUS;
                  2: alpha[pos*8 +: 8] = 8'h00;
                  default: alpha[pos*8 +: 8] = alpha[((pos + 1) % 16)*8 +: 8];
               endcase
            end
            default: ;
         endcase
         if (p == 3)
            radix = 5'd2;
         if (p == 4)
            radix = 5'd16;
         set_alphabet(radix, alpha[63:0], alpha[127:64]);
         calm_mode = (p == 6);
         for (int i = 0; i < 29; i++)
            send_number(random_number());
      end
      wait_idle();
      calm_mode = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_decimal_defaults();
      test_radix_extremes();
      test_invalid_alphabets();
      test_random_conversions();
      wait_idle();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_text.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
